// ===== design/tpc_pkg.sv =====
// shared types, constants and symbol mapping for the trie prefix counter
package tpc_pkg;

    localparam int NODE_COUNT    = 16384;
    localparam int ALPHABET_SIZE = 64;
    localparam int COUNT_BITS    = 24;
    localparam int NODE_BITS     = $clog2(NODE_COUNT);
    localparam int SYM_BITS      = $clog2(ALPHABET_SIZE);
    localparam int SLOT_BITS     = NODE_BITS + SYM_BITS;

    localparam logic [NODE_BITS-1:0]  NODE_ROOT = '0;
    localparam logic [NODE_BITS-1:0]  NODE_LAST = NODE_BITS'(NODE_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef struct packed {
        t_req       req_type;
        logic [7:0] char_byte;
        logic       word_start;
        logic       word_end;
        logic       empty_word;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] prefix_count;
        logic                  overflow_seen;
    } t_out_item;

    // one node table entry: owner tag plus pass count
    typedef struct packed {
        logic [NODE_BITS-1:0]  parent;
        logic [SYM_BITS-1:0]   sym;
        logic [COUNT_BITS-1:0] cnt;
    } t_node_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHILD,
        S_NODE,
        S_EVAL,
        S_RES_RD,
        S_RES_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic node_rd_cand;
        logic eval;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic walk;
        logic result_due;
        logic out_free;
    } t_dp_status;

    function automatic logic [SYM_BITS-1:0] map_symbol(input logic [7:0] b);
        logic [7:0] s;
        s = 8'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            s = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h7a) begin
            s = b - 8'h61 + 8'd10;
        end else if (b >= 8'h41 && b <= 8'h5a) begin
            s = b - 8'h41 + 8'd36;
        end
        return SYM_BITS'(s % ALPHABET_SIZE);
    endfunction

endpackage

// ===== design/tpc_ctrl.sv =====
// sequencer for the trie prefix counter: one beat at a time through the walk
module tpc_ctrl import tpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.req) inside
                    REQ_INSERT, REQ_QUERY: begin
                        if (i_status.walk) begin
                            n_state = S_CHILD;
                        end else if (i_status.result_due) begin
                            n_state = S_RES_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CHILD:  n_state = S_NODE;
            S_NODE:   n_state = S_EVAL;
            S_EVAL: begin
                if (i_status.result_due) begin
                    n_state = S_RES_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RES_RD: n_state = S_RES_OUT;
            S_RES_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_DECODE:  o_cmd.decode       = 1'b1;
            S_CHILD:   o_cmd              = '0;
            S_NODE:    o_cmd.node_rd_cand = 1'b1;
            S_EVAL:    o_cmd.eval         = 1'b1;
            S_RES_RD:  o_cmd              = '0;
            S_RES_OUT: o_cmd.load_out     = i_status.out_free;
            default:   o_cmd              = '0;
        endcase
    end

endmodule

// ===== design/tpc_dp.sv =====
// datapath: child table, node table, walk registers and result register
module tpc_dp import tpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;

    logic [NODE_BITS-1:0] r_child_mem [CHILD_DEPTH];
    t_node_entry          r_node_mem  [NODE_COUNT];

    logic [NODE_BITS-1:0]  r_child_rd;
    t_node_entry           r_node_rd;

    t_req                  r_req;
    logic                  r_start;
    logic                  r_end;
    logic                  r_empty;
    logic [SYM_BITS-1:0]   r_sym;

    logic [NODE_BITS-1:0]  r_cur;
    logic [NODE_BITS-1:0]  r_used;
    logic [NODE_BITS-1:0]  r_cand;
    logic                  r_miss;
    logic                  r_ovf;
    logic [COUNT_BITS-1:0] r_root_cnt;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_is_walk_req;
    logic                  w_hit;
    logic [NODE_BITS-1:0]  w_new_node;
    logic [SLOT_BITS-1:0]  w_slot;
    logic [NODE_BITS-1:0]  w_node_rd_addr;

    logic                  w_child_we;
    logic                  w_node_we;
    logic [NODE_BITS-1:0]  w_node_wr_addr;
    t_node_entry           w_node_wr_data;

    assign w_is_walk_req = (r_req == REQ_INSERT) || (r_req == REQ_QUERY);
    assign w_new_node    = r_used + 1'b1;
    assign w_slot        = {r_cur, r_sym};
    assign w_node_rd_addr = i_cmd.node_rd_cand ? r_child_rd : r_cur;

    // a stored pointer only counts when the target node names this parent and symbol
    assign w_hit = (r_cand != NODE_ROOT) && (r_cand <= r_used)
                   && (r_node_rd.parent == r_cur) && (r_node_rd.sym == r_sym);

    assign o_status.req        = r_req;
    assign o_status.walk       = w_is_walk_req && !r_empty && !(r_miss && !r_start);
    assign o_status.result_due = (r_req == REQ_QUERY) && (r_end || r_empty);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // memories
    always_ff @(posedge i_clk) begin
        if (w_child_we) begin
            r_child_mem[w_slot] <= w_new_node;
        end
        r_child_rd <= r_child_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_wr_addr] <= w_node_wr_data;
        end
        r_node_rd <= r_node_mem[w_node_rd_addr];
    end

    // table writes at evaluation
    always_comb begin
        w_child_we     = 1'b0;
        w_node_we      = 1'b0;
        w_node_wr_addr = r_cand;
        w_node_wr_data = '{parent: r_cur, sym: r_sym, cnt: r_node_rd.cnt + 1'b1};
        if (i_cmd.eval && r_req == REQ_INSERT) begin
            if (w_hit) begin
                w_node_we = (r_node_rd.cnt != COUNT_MAX);
            end else if (r_used != NODE_LAST) begin
                w_child_we     = 1'b1;
                w_node_we      = 1'b1;
                w_node_wr_addr = w_new_node;
                w_node_wr_data = '{parent: r_cur, sym: r_sym, cnt: COUNT_BITS'(1)};
            end
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_req   <= i_in_item.req_type;
            r_start <= i_in_item.word_start;
            r_end   <= i_in_item.word_end;
            r_empty <= i_in_item.empty_word;
            r_sym   <= map_symbol(i_in_item.char_byte);
        end
        if (i_cmd.node_rd_cand) begin
            r_cand <= r_child_rd;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= NODE_ROOT;
            r_used     <= NODE_ROOT;
            r_miss     <= 1'b0;
            r_ovf      <= 1'b0;
            r_root_cnt <= '0;
        end else if (i_cmd.decode) begin
            case (r_req) inside
                REQ_CLEAR: begin
                    r_cur      <= NODE_ROOT;
                    r_used     <= NODE_ROOT;
                    r_miss     <= 1'b0;
                    r_root_cnt <= '0;
                end
                REQ_INSERT, REQ_QUERY: begin
                    if (r_start || r_empty) begin
                        r_cur  <= NODE_ROOT;
                        r_miss <= 1'b0;
                        if (r_req == REQ_INSERT) begin
                            if (r_root_cnt == COUNT_MAX) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_root_cnt <= r_root_cnt + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.eval) begin
            if (w_hit) begin
                r_cur <= r_cand;
                if (r_req == REQ_INSERT && r_node_rd.cnt == COUNT_MAX) begin
                    r_ovf <= 1'b1;
                end
            end else if (r_req == REQ_INSERT) begin
                if (r_used != NODE_LAST) begin
                    r_used <= w_new_node;
                    r_cur  <= w_new_node;
                end else begin
                    r_ovf  <= 1'b1;
                    r_miss <= 1'b1;
                end
            end else begin
                r_miss <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.overflow_seen <= r_ovf;
            if (r_miss) begin
                r_out_item.prefix_count <= '0;
            end else if (r_cur == NODE_ROOT) begin
                r_out_item.prefix_count <= r_root_cnt;
            end else begin
                r_out_item.prefix_count <= r_node_rd.cnt;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_used)
        else $error("current node beyond allocated nodes");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken beat");
`endif

endmodule

// ===== design/trie_prefix_counter.sv =====
// top level of the trie prefix counter: sequencer plus datapath
// Character-serial prefix-count trie. Each input beat carries one byte of a word with
// start/end marks and a request (insert, query, clear). Bytes map to 6-bit symbols:
// digits give 0-9, lower-case letters 10-35, capitals 36-61, anything else 0. Inserts
// bump the pass count of every node on the path, allocating nodes as needed; a query
// beat that ends a word (or an empty word) returns the pass count of the node reached,
// or 0 when the path broke, with the sticky overflow flag. Beats are handled one at a
// time: decode, then child read, node read and evaluation for a walking beat, then
// result read and output load (waiting for the output side) for a query with a result.
// The walk reads two synchronous memories back to back: the child table (node x symbol
// -> child) and the node table (owner tag and pass count). Each node entry records its
// parent and symbol, so a child pointer left over from before a clear is rejected on
// compare; hence clear only resets registers and there is no clearing pass after
// reset. The root count lives in a register. When the node pool is full or a count
// saturates, the overflow flag sets and stays set until reset.
module trie_prefix_counter import tpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: accepts a beat only when idle
    tpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: tables, walk state and the output register
    tpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the trie prefix counter with its own trie predictor
`timescale 1ns / 100ps

module tb_top;
    import tpc_pkg::*;

    // the one request code the package leaves unnamed
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         QUIET_CYCLES = 16;
    localparam int         LONG_WORD    = 120;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // beats waiting for the driver, counted in and out
    t_in_item  beat_pend[$];
    int        beats_queued = 0;
    int        beats_taken  = 0;

    // prefix counts still owed by the block, oldest first
    t_out_item count_due[$];
    t_out_item seen_want;

    // idle chances in percent, set per phase
    int        send_idle = 0;
    int        recv_idle = 0;
    int        fail_cnt  = 0;
    int        cycle_cnt = 0;

    // predictor state: sparse child links keyed by node and symbol
    int                    child_link[int];
    logic [COUNT_BITS-1:0] node_pass[NODE_COUNT];
    int                    alloc_top = 0;
    int                    walk_node = 0;
    logic                  walk_lost = 1'b0;
    logic                  sat_seen  = 1'b0;

    logic [7:0]            deep_prefix[8];
    string                 common_chars = "abcAB01z";

    trie_prefix_counter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // invert after half a period
    always #2 clk = ~clk;

    function automatic logic [SYM_BITS-1:0] char_to_sym(input logic [7:0] c);
        int v;
        v = 0;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "a" && c <= "z") begin
            v = c - "a" + 10;
        end else if (c >= "A" && c <= "Z") begin
            v = c - "A" + 36;
        end
        return SYM_BITS'(v % ALPHABET_SIZE);
    endfunction

    // saturating pass count, saturation is sticky
    function automatic void bump_count(input int n);
        if (node_pass[n] == COUNT_MAX) begin
            sat_seen = 1'b1;
        end else begin
            node_pass[n] = node_pass[n] + 1'b1;
        end
    endfunction

    // advance the trie by one accepted beat and queue any prefix count it owes
    function automatic void predict_beat(input t_in_item it);
        logic [1:0] req;
        int         slot;
        t_out_item  res;
        req = it.req_type;
        if (req == REQ_CLEAR) begin
            for (int n = 0; n <= alloc_top; n++) begin
                node_pass[n] = '0;
            end
            child_link.delete();
            alloc_top = 0;
            walk_node = 0;
            walk_lost = 1'b0;
        end else if (req != REQ_UNUSED) begin
            if (it.empty_word || it.word_start) begin
                walk_node = 0;
                walk_lost = 1'b0;
                if (req == REQ_INSERT) begin
                    bump_count(0);
                end
            end
            if (!it.empty_word && !walk_lost) begin
                slot = walk_node * ALPHABET_SIZE + int'(char_to_sym(it.char_byte));
                if (!child_link.exists(slot)) begin
                    if (req == REQ_INSERT && alloc_top + 1 < NODE_COUNT) begin
                        alloc_top++;
                        child_link[slot] = alloc_top;
                        walk_node = alloc_top;
                        bump_count(walk_node);
                    end else begin
                        // pool exhausted on insert, or a query fell off the trie
                        if (req == REQ_INSERT) begin
                            sat_seen = 1'b1;
                        end
                        walk_lost = 1'b1;
                    end
                end else begin
                    walk_node = child_link[slot];
                    if (req == REQ_INSERT) begin
                        bump_count(walk_node);
                    end
                end
            end
            if (req == REQ_QUERY && (it.word_end || it.empty_word)) begin
                res.prefix_count  = walk_lost ? '0 : node_pass[walk_node];
                res.overflow_seen = sat_seen;
                count_due.push_back(res);
            end
        end
    endfunction

    task automatic push_beat(input logic [1:0] req, input logic [7:0] c,
                             input logic st, input logic en, input logic em);
        t_in_item it;
        it.req_type   = t_req'(req);
        it.char_byte  = c;
        it.word_start = st;
        it.word_end   = en;
        it.empty_word = em;
        beat_pend.push_back(it);
        beats_queued++;
    endtask

    task automatic push_word(input logic [1:0] req, input string w);
        for (int k = 0; k < w.len(); k++) begin
            push_beat(req, w[k], k == 0, k == w.len() - 1, 1'b0);
        end
    endtask

    // mostly from a small set so that words share prefixes
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        if ($urandom_range(99) < 80) begin
            c = common_chars[$urandom_range(common_chars.len() - 1)];
        end else begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // well-formed words with random content, plus noise, empty words and clears
    task automatic push_random(input int n);
        int         made;
        int         pick;
        int         len;
        logic [1:0] req;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_beat(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                made++;
            end else if (pick < 10) begin
                push_beat(REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end else if (pick < 15) begin
                req = (pick < 12) ? REQ_INSERT : REQ_QUERY;
                push_beat(req, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'b1);
                made++;
            end else begin
                req = ($urandom_range(99) < 55) ? REQ_INSERT : REQ_QUERY;
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    // now and then leave the end mark off, so the next word runs on
                    push_beat(req, rand_char(), k == 0,
                              (k == len - 1) && (pick >= 18), 1'b0);
                end
                made += len;
            end
        end
    endtask

    // sender holds back until every beat is taken and every count has come
    task automatic drain_all();
        while (beats_taken != beats_queued) @(posedge clk);
        while (count_due.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // driver: one beat presented at a time, held until taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_beat(in_item);
                beats_taken++;
            end
            if (!in_valid || in_ready) begin
                if (beat_pend.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_item  <= beat_pend.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest owed count
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (count_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual count %0d overflow %0b",
                         $time, out_item.prefix_count, out_item.overflow_seen);
                fail_cnt++;
            end else begin
                seen_want = count_due.pop_front();
                if (seen_want.prefix_count !== out_item.prefix_count) begin
                    $display("%0t: prefix_count expected %0d actual %0d", $time,
                             seen_want.prefix_count, out_item.prefix_count);
                    fail_cnt++;
                end
                if (seen_want.overflow_seen !== out_item.overflow_seen) begin
                    $display("%0t: overflow_seen expected %0b actual %0b", $time,
                             seen_want.overflow_seen, out_item.overflow_seen);
                    fail_cnt++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < NODE_COUNT; n++) begin
            node_pass[n] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 36;
        recv_idle = 61;

        // directed: empty word at the root, both byte extremes
        push_beat(REQ_INSERT, 8'h00, 1'b0, 1'b0, 1'b1);
        push_beat(REQ_QUERY, 8'hff, 1'b1, 1'b1, 1'b1);
        push_word(REQ_INSERT, "ab");
        push_word(REQ_INSERT, "aZ9");
        push_word(REQ_QUERY, "a");
        push_word(REQ_QUERY, "ab");
        // broken path, and a byte without word start after it
        push_word(REQ_QUERY, "ax");
        push_beat(REQ_QUERY, "b", 1'b0, 1'b1, 1'b0);
        // unmapped bytes share symbol zero with the digit 0
        push_beat(REQ_INSERT, 8'h00, 1'b1, 1'b1, 1'b0);
        push_beat(REQ_INSERT, 8'hff, 1'b1, 1'b1, 1'b0);
        push_word(REQ_QUERY, "0");
        // a query carrying on from where an insert stopped
        push_beat(REQ_INSERT, "a", 1'b1, 1'b0, 1'b0);
        push_beat(REQ_QUERY, "b", 1'b0, 1'b1, 1'b0);
        push_beat(REQ_UNUSED, "z", 1'b1, 1'b1, 1'b0);
        push_beat(REQ_CLEAR, "Z", 1'b0, 1'b0, 1'b0);
        push_word(REQ_QUERY, "a");
        push_beat(REQ_QUERY, "9", 1'b1, 1'b1, 1'b1);
        push_word(REQ_INSERT, "z");
        push_word(REQ_QUERY, "z");
        drain_all();

        push_random(600);
        drain_all();

        send_idle = 61;
        recv_idle = 36;
        push_random(600);
        drain_all();

        send_idle = 0;
        recv_idle = 0;
        // one long word runs deep, its tail goes on past the queried prefixes
        push_beat(REQ_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < LONG_WORD; k++) begin
            if (k < 8) begin
                deep_prefix[k] = 8'($urandom_range(255));
                push_beat(REQ_INSERT, deep_prefix[k], k == 0, 1'b0, 1'b0);
            end else begin
                push_beat(REQ_INSERT, 8'($urandom_range(255)), 1'b0,
                          k == LONG_WORD - 1, 1'b0);
            end
        end
        for (int d = 1; d <= 8; d++) begin
            for (int k = 0; k < d; k++) begin
                push_beat(REQ_QUERY, deep_prefix[k], k == 0, k == d - 1, 1'b0);
            end
        end
        push_beat(REQ_QUERY, 8'h00, 1'b0, 1'b0, 1'b1);
        push_word(REQ_INSERT, "ab");
        push_word(REQ_QUERY, "ab");
        push_beat(REQ_CLEAR, 8'hff, 1'b1, 1'b1, 1'b1);
        push_random(150);
        drain_all();

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
